// ----- hw/rtl/sti_pkg.sv -----
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants of the sphere triangle index generator.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int unsigned IdxW    = 20;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned DefaultMaxSlices = 1024;
  localparam int unsigned DefaultMaxStacks = 1024;

  localparam logic [CfgIdxW-1:0] CfgSliceCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStackCount = 1'b1;

  localparam logic [CfgW-1:0] SliceReset = 11'd32;
  localparam logic [CfgW-1:0] StackReset = 11'd16;

  typedef struct packed {
    logic [IdxW-1:0] index_first;
    logic [IdxW-1:0] index_second;
    logic [IdxW-1:0] index_third;
    logic            tri_valid;
    logic            last_triangle;
  } tri_t;

endpackage

// ----- hw/rtl/sti_cfg.sv -----
// ----------------------------------------------------------------------------
// sti_cfg
// Slice and stack count registers, saturated to their legal ranges.
// ----------------------------------------------------------------------------
module sti_cfg import sti_pkg::*; #(
  parameter int unsigned MAX_SLICES = DefaultMaxSlices,
  parameter int unsigned MAX_STACKS = DefaultMaxStacks,
  localparam int unsigned SW = $clog2(MAX_SLICES + 1),
  localparam int unsigned TW = $clog2(MAX_STACKS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output logic [SW-1:0]      slices_o,
  output logic [TW-1:0]      stacks_o
);

  logic [CfgW-1:0] slice_q, slice_d;
  logic [CfgW-1:0] stack_q, stack_d;

  always_comb begin
    slice_d = slice_q;
    stack_d = stack_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSliceCount: slice_d = cfg_data_i;
        CfgStackCount: stack_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= SliceReset;
      stack_q <= StackReset;
    end else begin
      slice_q <= slice_d;
      stack_q <= stack_d;
    end
  end

  always_comb begin
    if (32'(slice_q) < 32'd3) begin
      slices_o = SW'(3);
    end else if (32'(slice_q) > 32'(MAX_SLICES)) begin
      slices_o = SW'(MAX_SLICES);
    end else begin
      slices_o = SW'(slice_q);
    end
    if (32'(stack_q) < 32'd3) begin
      stacks_o = TW'(3);
    end else if (32'(stack_q) > 32'(MAX_STACKS)) begin
      stacks_o = TW'(MAX_STACKS);
    end else begin
      stacks_o = TW'(stack_q);
    end
  end

endmodule

// ----- hw/rtl/sti_walk.sv -----
// ----------------------------------------------------------------------------
// sti_walk
// Mesh position state and the triangle built from it for each request.
// ----------------------------------------------------------------------------
module sti_walk import sti_pkg::*; #(
  parameter int unsigned MAX_SLICES = DefaultMaxSlices,
  parameter int unsigned MAX_STACKS = DefaultMaxStacks,
  localparam int unsigned SW = $clog2(MAX_SLICES + 1),
  localparam int unsigned TW = $clog2(MAX_STACKS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          restart_i,
  input  logic [SW-1:0] slices_i,
  input  logic [TW-1:0] stacks_i,
  output tri_t          tri_o
);

  localparam int unsigned PW = $clog2(MAX_SLICES);
  localparam int unsigned BW = $clog2(MAX_STACKS);

  typedef enum logic [1:0] {
    PhTop  = 2'd0,
    PhMid  = 2'd1,
    PhBot  = 2'd2,
    PhDone = 2'd3
  } phase_e;

  phase_e          phase_q, phase_d, ph;
  logic [PW-1:0]   slice_q, slice_d, sp, nxt;
  logic [BW-1:0]   band_q, band_d, bp;
  logic [IdxW-1:0] ring_q, ring_d, rb, nr;
  logic            half_q, half_d, sh;
  logic [TW-1:0]   bands;
  logic            row_end, band_end;

  always_comb begin
    if (restart_i) begin
      ph = PhTop;
      sp = '0;
      bp = '0;
      rb = IdxW'(slices_i);
      sh = 1'b0;
    end else begin
      ph = phase_q;
      sp = slice_q;
      bp = band_q;
      rb = ring_q;
      sh = half_q;
    end

    bands    = stacks_i - TW'(3);
    row_end  = (SW'(sp) + SW'(1)) >= slices_i;
    band_end = (TW'(bp) + TW'(1)) >= bands;
    nxt      = row_end ? '0 : sp + PW'(1);
    nr       = rb + IdxW'(slices_i);

    phase_d = ph;
    slice_d = sp;
    band_d  = bp;
    ring_d  = rb;
    half_d  = sh;
    tri_o   = '0;

    case (ph)
      PhTop: begin
        tri_o.index_first  = IdxW'(sp);
        tri_o.index_second = rb + IdxW'(nxt);
        tri_o.index_third  = rb + IdxW'(sp);
        tri_o.tri_valid    = 1'b1;
        if (row_end) begin
          slice_d = '0;
          band_d  = '0;
          half_d  = 1'b0;
          phase_d = (bands != '0) ? PhMid : PhBot;
        end else begin
          slice_d = nxt;
        end
      end
      PhMid: begin
        tri_o.tri_valid = 1'b1;
        if (!sh) begin
          tri_o.index_first  = rb + IdxW'(sp);
          tri_o.index_second = nr + IdxW'(sp);
          tri_o.index_third  = nr + IdxW'(nxt);
          half_d = 1'b1;
        end else begin
          tri_o.index_first  = nr + IdxW'(nxt);
          tri_o.index_second = rb + IdxW'(nxt);
          tri_o.index_third  = rb + IdxW'(sp);
          half_d = 1'b0;
          if (row_end) begin
            slice_d = '0;
            ring_d  = nr;
            if (band_end) begin
              phase_d = PhBot;
            end else begin
              band_d = bp + BW'(1);
            end
          end else begin
            slice_d = nxt;
          end
        end
      end
      PhBot: begin
        tri_o.index_first   = rb + IdxW'(sp);
        tri_o.index_second  = rb + IdxW'(nxt);
        tri_o.index_third   = nr + IdxW'(sp);
        tri_o.tri_valid     = 1'b1;
        tri_o.last_triangle = row_end;
        if (row_end) begin
          phase_d = PhDone;
        end else begin
          slice_d = nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDone;
      slice_q <= '0;
      band_q  <= '0;
      ring_q  <= '0;
      half_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      slice_q <= slice_d;
      band_q  <= band_d;
      ring_q  <= ring_d;
      half_q  <= half_d;
    end
  end

  // final triangle closes the mesh
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tri_o.last_triangle |=> phase_q == PhDone)
    else $error("last triangle did not end the mesh");

  // a restart lands on the first upper ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && restart_i |=> ring_q == IdxW'($past(slices_i)))
    else $error("ring base wrong after restart");

  // half-quad toggle only while in the middle bands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> phase_q == PhMid)
    else $error("second half set outside middle bands");

endmodule

// ----- hw/rtl/sphere_triangle_index_generator_core.sv -----
// ----------------------------------------------------------------------------
// sphere_triangle_index_generator_core
// Streams the triangle index list of a UV sphere, one triangle per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/restart_i; a transfer takes place when
//   in_valid_i is high and in_stall_o low. restart_i = 1 starts the mesh
//   from its first triangle in the same request. Each request yields one
//   result on out_valid_o with three vertex indices, tri_valid_o and
//   last_triangle_o; tri_valid_o is low once the mesh has ended.
//   The single result register after the index logic gives the result in
//   the cycle after the request; one request is taken per unstalled cycle.
//   in_stall_o rises only while a result is held and out_stall_i is high,
//   so a stalled receiver holds the result and back-pressures requests.
//   The config channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
//   is always ready and writes slice or stack count; values are saturated
//   to [3, MAX_*]. Write it only while the block is idle.
//   Reset leaves counts at 32 slices and 16 stacks and the mesh finished,
//   so requests before a restart return tri_valid_o = 0.
// ----------------------------------------------------------------------------
module sphere_triangle_index_generator_core import sti_pkg::*; #(
  parameter int unsigned MAX_SLICES = DefaultMaxSlices,
  parameter int unsigned MAX_STACKS = DefaultMaxStacks
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IdxW-1:0]    index_first_o,
  output logic [IdxW-1:0]    index_second_o,
  output logic [IdxW-1:0]    index_third_o,
  output logic               tri_valid_o,
  output logic               last_triangle_o
);

  localparam int unsigned SW = $clog2(MAX_SLICES + 1);
  localparam int unsigned TW = $clog2(MAX_STACKS + 1);

  logic          accept;
  logic [SW-1:0] slices;
  logic [TW-1:0] stacks;
  tri_t          tri_d, tri_q;
  logic          out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  sti_cfg #(
    .MAX_SLICES(MAX_SLICES),
    .MAX_STACKS(MAX_STACKS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .slices_o   (slices),
    .stacks_o   (stacks)
  );

  sti_walk #(
    .MAX_SLICES(MAX_SLICES),
    .MAX_STACKS(MAX_STACKS)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .restart_i(restart_i),
    .slices_i (slices),
    .stacks_i (stacks),
    .tri_o    (tri_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tri_q <= tri_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign index_first_o   = tri_q.index_first;
  assign index_second_o  = tri_q.index_second;
  assign index_third_o   = tri_q.index_third;
  assign tri_valid_o     = tri_q.tri_valid;
  assign last_triangle_o = tri_q.last_triangle;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && tri_q.last_triangle |-> tri_q.tri_valid)
    else $error("last flag on an empty result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slices >= SW'(3) && stacks >= TW'(3))
    else $error("counts below minimum after saturation");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sphere triangle index generator. Requests with
// and without restart are streamed under a range of slice and stack counts,
// saturating values included. A tracker class predicts each triangle from its
// own copy of the mesh walk and compares it with the transfers at the output,
// while both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import sti_pkg::*;

  localparam int unsigned ItemTarget = 1450;

  typedef enum logic [1:0] {MeshTop, MeshMiddle, MeshBottom, MeshDone} mesh_phase_e;

  class tri_index_tracker;
    logic [CfgW-1:0] slices_reg;
    logic [CfgW-1:0] stacks_reg;
    mesh_phase_e     phase;
    logic [9:0]      slice_pos;
    logic [9:0]      band_pos;
    logic [IdxW-1:0] ring_base;
    bit              second_half;
    tri_t            expected_tris[$];
    int unsigned     mismatch_cnt;

    function new();
      slices_reg   = SliceReset;
      stacks_reg   = StackReset;
      phase        = MeshDone;
      slice_pos    = '0;
      band_pos     = '0;
      ring_base    = '0;
      second_half  = 1'b0;
      mismatch_cnt = 0;
    endfunction

    function int unsigned sat_count(logic [CfgW-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return 32'(v);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CfgSliceCount: slices_reg = val;
        CfgStackCount: stacks_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_tris.size();
    endfunction

    function tri_t pack_tri(logic [IdxW-1:0] a, logic [IdxW-1:0] b, logic [IdxW-1:0] c,
                            bit last);
      tri_t res;
      res.index_first   = a;
      res.index_second  = b;
      res.index_third   = c;
      res.tri_valid     = 1'b1;
      res.last_triangle = last;
      return res;
    endfunction

    function void note_request(bit restart);
      int unsigned     s, t, sp, nxt;
      int              bands;
      bit              row_end;
      logic [IdxW-1:0] sp_w, nxt_w, rb, nr;
      tri_t            res;
      s     = sat_count(slices_reg, DefaultMaxSlices);
      t     = sat_count(stacks_reg, DefaultMaxStacks);
      bands = int'(t) - 3;
      if (restart) begin
        phase       = MeshTop;
        slice_pos   = '0;
        band_pos    = '0;
        ring_base   = IdxW'(s);
        second_half = 1'b0;
      end
      sp      = 32'(slice_pos);
      row_end = (sp + 1 >= s);
      nxt     = row_end ? 0 : sp + 1;
      sp_w    = IdxW'(sp);
      nxt_w   = IdxW'(nxt);
      rb      = ring_base;
      nr      = rb + IdxW'(s);
      res     = '0;
      case (phase)
        MeshTop: begin
          res = pack_tri(sp_w, rb + nxt_w, rb + sp_w, 1'b0);
          if (row_end) begin
            slice_pos   = '0;
            band_pos    = '0;
            second_half = 1'b0;
            phase       = (bands > 0) ? MeshMiddle : MeshBottom;
          end else begin
            slice_pos = 10'(sp + 1);
          end
        end
        MeshMiddle: begin
          if (!second_half) begin
            res         = pack_tri(rb + sp_w, nr + sp_w, nr + nxt_w, 1'b0);
            second_half = 1'b1;
          end else begin
            res         = pack_tri(nr + nxt_w, rb + nxt_w, rb + sp_w, 1'b0);
            second_half = 1'b0;
            if (row_end) begin
              slice_pos = '0;
              ring_base = nr;
              if (int'(band_pos) + 1 >= bands) phase = MeshBottom;
              else band_pos = band_pos + 1'b1;
            end else begin
              slice_pos = 10'(sp + 1);
            end
          end
        end
        MeshBottom: begin
          res = pack_tri(rb + sp_w, rb + nxt_w, nr + sp_w, row_end);
          if (row_end) phase = MeshDone;
          else slice_pos = 10'(sp + 1);
        end
        default: res = '0;
      endcase
      expected_tris.push_back(res);
    endfunction

    function void flag(string what, logic [IdxW-1:0] want, logic [IdxW-1:0] seen);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, seen);
    endfunction

    function void check_triangle(tri_t got);
      tri_t want;
      if (expected_tris.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: transfer with no triangle outstanding (%0d %0d %0d)", $time,
                   got.index_first, got.index_second, got.index_third);
        return;
      end
      want = expected_tris.pop_front();
      if (got.index_first !== want.index_first)
        flag("index_first", want.index_first, got.index_first);
      if (got.index_second !== want.index_second)
        flag("index_second", want.index_second, got.index_second);
      if (got.index_third !== want.index_third)
        flag("index_third", want.index_third, got.index_third);
      if (got.tri_valid !== want.tri_valid)
        flag("tri_valid", IdxW'(want.tri_valid), IdxW'(got.tri_valid));
      if (got.last_triangle !== want.last_triangle)
        flag("last_triangle", IdxW'(want.last_triangle), IdxW'(got.last_triangle));
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgSliceCount;
  logic [CfgW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               restart_i   = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [IdxW-1:0]    index_first_o;
  logic [IdxW-1:0]    index_second_o;
  logic [IdxW-1:0]    index_third_o;
  logic               tri_valid_o;
  logic               last_triangle_o;

  tri_index_tracker board;
  int unsigned      items_sent  = 0;
  bit               tx_idle_on  = 1'b1;
  bit               rx_idle_on  = 1'b1;
  bit               hold_req    = 1'b0;
  logic             rx_hold     = 1'b0;
  int unsigned      rx_wait     = 0;
  tri_t             rx_tri;

  sphere_triangle_index_generator_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .index_first_o   (index_first_o),
    .index_second_o  (index_second_o),
    .index_third_o   (index_third_o),
    .tri_valid_o     (tri_valid_o),
    .last_triangle_o (last_triangle_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: check each transfer, then stall for a drawn number of cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        rx_tri.index_first   = index_first_o;
        rx_tri.index_second  = index_second_o;
        rx_tri.index_third   = index_third_o;
        rx_tri.tri_valid     = tri_valid_o;
        rx_tri.last_triangle = last_triangle_o;
        board.check_triangle(rx_tri);
        rx_wait = rx_idle_on ? $urandom_range(0, 10) : 0;
      end
      if (rx_hold) begin
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the block fills and stalls its input.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (60) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic send_item(input bit restart);
    int unsigned gap;
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(restart);
    items_sent++;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_mesh(input int unsigned n, input bit first_restart, input bit mid_restarts);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) send_item(first_restart);
      else send_item(mid_restarts && ($urandom_range(0, 49) == 0));
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
  endtask

  task automatic configure(input bit wr_slices, input logic [CfgW-1:0] slices,
                           input bit wr_stacks, input logic [CfgW-1:0] stacks);
    if (wr_slices) cfg_put(CfgSliceCount, slices);
    if (wr_stacks) cfg_put(CfgStackCount, stacks);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] extreme_count();
    case ($urandom_range(0, 4))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'd1025;
      3: return 11'd2047;
      default: return CfgW'($urandom_range(0, 2047));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned     s, t, n;
    bit              big;
    logic [CfgW-1:0] slices, stacks;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no restart yet, defaults, smallest mesh, saturation both ways
    run_mesh(2, 1'b0, 1'b0);
    run_mesh(2, 1'b1, 1'b0);
    drain();
    configure(1'b1, 11'd0, 1'b1, 11'd1);
    run_mesh(7, 1'b1, 1'b0);
    drain();
    configure(1'b1, 11'd2047, 1'b1, 11'd4);
    run_mesh(3, 1'b1, 1'b0);
    drain();
    configure(1'b1, 11'd4, 1'b1, 11'd2047);
    run_mesh(13, 1'b1, 1'b0);
    drain();

    // back-pressure: sender flat out while the receiver holds off
    configure(1'b1, 11'd32, 1'b1, 11'd16);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 1'b1;
    run_mesh(100, 1'b1, 1'b0);
    drain();

    while (items_sent < ItemTarget) begin
      big = ($urandom_range(0, 7) == 0);
      if (big) begin
        slices = extreme_count();
        stacks = extreme_count();
      end else begin
        slices = CfgW'($urandom_range(0, 10));
        stacks = CfgW'($urandom_range(0, 8));
      end
      configure($urandom_range(0, 3) != 0, slices, $urandom_range(0, 3) != 0, stacks);
      s = board.sat_count(board.slices_reg, DefaultMaxSlices);
      t = board.sat_count(board.stacks_reg, DefaultMaxStacks);
      if (big || s * t > 200) n = $urandom_range(40, 120);
      else n = 2 * s * (t - 2) + $urandom_range(0, 3);
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      run_mesh(n, $urandom_range(0, 9) != 0, 1'b1);
      drain();
    end

    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.mismatch_cnt == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d triangles still outstanding", board.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sti_pkg.sv
hw/rtl/sti_cfg.sv
hw/rtl/sti_walk.sv
hw/rtl/sphere_triangle_index_generator_core.sv
bench/tb.sv
